// ===== rtl/wmra_pkg.sv =====
`timescale 1ns / 1ps
package wmra_pkg;

  localparam int unsigned OpcodeW  = 2;
  localparam int unsigned SymbolW  = 8;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned AnswerW  = 11;

  typedef enum logic [OpcodeW-1:0] {
    OP_LOAD   = 2'd0,
    OP_ACCESS = 2'd1,
    OP_RANK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SymbolW-1:0] symbol;
    logic [IndexW-1:0]  index;
    logic               last_load;
  } req_t;

  typedef struct packed {
    logic [AnswerW-1:0] answer;
    logic               query_kind;
    logic               error;
  } rsp_t;

endpackage

// ===== rtl/wmra_ram.sv =====
`timescale 1ns / 1ps
module wmra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/wavelet_matrix_rank_access_core.sv =====
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/ready   | wmra_pkg::req_t
// out     | output    | out_valid/ready  | wmra_pkg::rsp_t
//
// The last load starts a build over the N loaded symbols:
// one copy pass, then three passes per layer (count, partition, copy back).
// The layer walk of a query reads one prefix entry per layer for access and two for rank
// (start and end position); the request is taken in S_IDLE and the result is held in S_OUT.
// Reset clears the length, the built flag and the layer zero counts.
// A held result or a running build blocks every new transfer.
`timescale 1ns / 1ps
module wavelet_matrix_rank_access_core #(
  parameter int unsigned MAX_SYMBOLS = 1024,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wmra_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wmra_pkg::rsp_t   out_data_o
);
  import wmra_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SYMBOLS);
  localparam int unsigned LW  = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned YW  = (SYMBOL_BITS > 1) ? $clog2(SYMBOL_BITS) : 1;
  localparam int unsigned PW  = AW + YW;
  localparam int unsigned PD  = SYMBOL_BITS * MAX_SYMBOLS;
  localparam int unsigned SW  = SYMBOL_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_L_RD, S_L_WR, S_P_RD, S_P_WR, S_P_CP_RD,
    S_P_CP_WR, S_Q_RD, S_Q_CALC, S_OUT
  } state_e;

  state_e           state_q;
  logic [LW-1:0]    len_q;
  logic             built_q;
  logic [LW-1:0]    zc_q [SYMBOL_BITS];
  logic [YW-1:0]    lay_q;
  logic [LW-1:0]    p_q, ones_q, zi_q, oi_q;
  logic [LW-1:0]    s_q, e_q;
  logic [SW-1:0]    sym_q, acc_q;
  logic             kind_q, sel_e_q;
  rsp_t             rsp_q;

  // Load buffer (loaded order), buffer A (working order), buffer B (partition scratch)
  logic           a_we, b_we;
  logic [AW-1:0]  a_wa, a_ra, b_wa, b_ra;
  logic [SW-1:0]  a_wd, a_rd, b_wd, b_rd;
  logic           p_we;
  logic [PW-1:0]  p_wa, p_ra;
  logic [LW:0]    p_wd, p_rd;
  logic           l_we;
  logic [AW-1:0]  l_wa, l_ra;
  logic [SW-1:0]  l_wd, l_rd;

  wmra_ram #(.Width(SW), .Depth(MAX_SYMBOLS)) u_load (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd));
  wmra_ram #(.Width(SW), .Depth(MAX_SYMBOLS)) u_ord (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));
  wmra_ram #(.Width(SW), .Depth(MAX_SYMBOLS)) u_scr (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));
  // Entry holds {layer bit, prefix one count}.
  wmra_ram #(.Width(LW + 1), .Depth(PD)) u_pref (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));

  logic [LW-1:0] q_pos;
  logic          a_bit, q_bit;
  logic [LW-1:0] ones_rd, mapped;
  logic [PW-1:0] lay_base;

  assign lay_base = PW'(lay_q) * PW'(MAX_SYMBOLS);
  assign a_bit    = a_rd[SW-1-32'(lay_q)];
  assign q_pos    = sel_e_q ? e_q : s_q;
  assign ones_rd  = (q_pos == '0) ? '0 : p_rd[LW-1:0];
  assign q_bit    = kind_q ? sym_q[SW-1-32'(lay_q)] : p_rd[LW];
  assign mapped   = q_bit ? LW'(zc_q[lay_q] + ones_rd) : LW'(q_pos - ones_rd);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  always_comb begin
    l_we = 1'b0; l_wa = built_q ? AW'(0) : len_q[AW-1:0]; l_wd = SW'(in_data_i.symbol);
    l_ra = p_q[AW-1:0];
    a_we = 1'b0; a_wa = p_q[AW-1:0]; a_wd = l_rd; a_ra = p_q[AW-1:0];
    b_we = 1'b0; b_wa = a_bit ? oi_q[AW-1:0] : zi_q[AW-1:0]; b_wd = a_rd;
    b_ra = p_q[AW-1:0];
    p_we = 1'b0; p_wa = lay_base + PW'(p_q[AW-1:0]);
    p_wd = {a_bit, LW'(ones_q + LW'(a_bit))};
    p_ra = lay_base + PW'(q_pos[AW-1:0] - AW'(1));
    case (state_q)
      S_IDLE:    l_we = in_valid_i && (opcode_e'(in_data_i.opcode) == OP_LOAD)
                        && (built_q || (len_q < LW'(MAX_SYMBOLS)));
      S_CP_WR:   a_we = 1'b1;
      S_L_WR:    p_we = 1'b1;
      S_P_WR:    b_we = 1'b1;
      S_P_CP_WR: begin
        a_we = 1'b1;
        a_wd = b_rd;
      end
      S_Q_RD:    if (!kind_q) p_ra = lay_base + PW'(s_q[AW-1:0]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      built_q <= 1'b0;
      for (int i = 0; i < SYMBOL_BITS; i++) zc_q[i] <= '0;
      lay_q <= '0; p_q <= '0; ones_q <= '0; zi_q <= '0; oi_q <= '0;
      s_q <= '0; e_q <= '0; sym_q <= '0; acc_q <= '0;
      kind_q <= 1'b0; sel_e_q <= 1'b0; rsp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          case (opcode_e'(in_data_i.opcode))
            OP_LOAD: begin
              if (built_q) begin
                built_q <= 1'b0;
                len_q   <= LW'(1);
              end else if (len_q < LW'(MAX_SYMBOLS)) begin
                len_q <= len_q + LW'(1);
              end
              if (in_data_i.last_load) begin
                p_q     <= '0;
                state_q <= S_CP_RD;
              end
            end
            OP_ACCESS, OP_RANK: begin
              kind_q  <= (opcode_e'(in_data_i.opcode) == OP_RANK);
              sym_q   <= SW'(in_data_i.symbol);
              lay_q   <= '0;
              acc_q   <= '0;
              sel_e_q <= 1'b0;
              s_q     <= (opcode_e'(in_data_i.opcode) == OP_RANK) ? '0
                         : LW'(in_data_i.index);
              e_q     <= LW'(in_data_i.index) + LW'(1);
              if (!built_q || (LW'(in_data_i.index) >= len_q)) begin
                rsp_q   <= '{answer: '0,
                             query_kind: (opcode_e'(in_data_i.opcode) == OP_RANK),
                             error: 1'b1};
                state_q <= S_OUT;
              end else begin
                state_q <= S_Q_RD;
              end
            end
            default: ;
          endcase
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          if (p_q + LW'(1) >= len_q) begin
            p_q <= '0; lay_q <= '0; ones_q <= '0;
            state_q <= S_L_RD;
          end else begin
            p_q <= p_q + LW'(1);
            state_q <= S_CP_RD;
          end
        end
        S_L_RD: state_q <= S_L_WR;
        S_L_WR: begin
          ones_q <= ones_q + LW'(a_bit);
          if (p_q + LW'(1) >= len_q) begin
            zc_q[lay_q] <= len_q - (ones_q + LW'(a_bit));
            zi_q <= '0;
            oi_q <= len_q - (ones_q + LW'(a_bit));
            p_q  <= '0;
            state_q <= S_P_RD;
          end else begin
            p_q <= p_q + LW'(1);
            state_q <= S_L_RD;
          end
        end
        S_P_RD: state_q <= S_P_WR;
        S_P_WR: begin
          if (a_bit) oi_q <= oi_q + LW'(1);
          else       zi_q <= zi_q + LW'(1);
          if (p_q + LW'(1) >= len_q) begin
            p_q <= '0;
            state_q <= S_P_CP_RD;
          end else begin
            p_q <= p_q + LW'(1);
            state_q <= S_P_RD;
          end
        end
        S_P_CP_RD: state_q <= S_P_CP_WR;
        S_P_CP_WR: begin
          if (p_q + LW'(1) >= len_q) begin
            p_q <= '0;
            ones_q <= '0;
            if (32'(lay_q) == SYMBOL_BITS - 1) begin
              built_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              lay_q <= lay_q + YW'(1);
              state_q <= S_L_RD;
            end
          end else begin
            p_q <= p_q + LW'(1);
            state_q <= S_P_CP_RD;
          end
        end
        S_Q_RD: state_q <= S_Q_CALC;
        S_Q_CALC: begin
          if (!kind_q) begin
            acc_q <= SW'({acc_q, p_rd[LW]});
            if (p_rd[LW]) s_q <= LW'(zc_q[lay_q] + (p_rd[LW-1:0] - LW'(1)));
            else          s_q <= s_q - p_rd[LW-1:0];
          end else if (!sel_e_q) begin
            s_q <= mapped;
          end else begin
            e_q <= mapped;
          end
          if (kind_q && !sel_e_q) begin
            sel_e_q <= 1'b1;
            state_q <= S_Q_RD;
          end else begin
            sel_e_q <= 1'b0;
            if (32'(lay_q) == SYMBOL_BITS - 1) begin
              rsp_q.query_kind <= kind_q;
              rsp_q.error      <= 1'b0;
              rsp_q.answer     <= kind_q ? AnswerW'(mapped - s_q)
                                         : AnswerW'({acc_q, p_rd[LW]});
              state_q <= S_OUT;
            end else begin
              lay_q <= lay_q + YW'(1);
              state_q <= S_Q_RD;
            end
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result held");
  a_built_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (len_q != '0)) else $error("built with empty sequence");
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_SYMBOLS)) else $error("length overflow");
  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("no return to idle");

endmodule
